// File: src/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg: shared types and constants of the key prefix compressor
// Holds the base store geometry, the length limits and the item record that
// the front end hands to the back end through the queue.
// ----------------------------------------------------------------------------
package kpc_pkg;

    localparam int BASE_DEPTH = 256;
    localparam int COUNT_CAP  = 255;
    localparam int KEEP_LEN   = (BASE_DEPTH < COUNT_CAP) ? BASE_DEPTH : COUNT_CAP;
    localparam int ADDR_W     = $clog2(BASE_DEPTH);
    localparam int LEN_W      = 8;
    localparam int BYTE_W     = 8;

    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef enum logic {
        REQ_BASE = 1'b0,
        REQ_KEY  = 1'b1
    } req_type_t;

    // One classified item as the back end needs it.
    typedef struct packed {
        req_type_t         kind;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              base_empty;
        logic              match;
    } kpc_item_t;

endpackage

// File: src/kpc_ram.sv
// ----------------------------------------------------------------------------
// kpc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/kpc_front.sv
// ----------------------------------------------------------------------------
// kpc_front: input side of the key prefix compressor
// Stores base bytes, tracks the base length, and looks up the base byte at
// the running key position so that each key byte leaves with its match flag.
// ----------------------------------------------------------------------------
module kpc_front
    import kpc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  req_type_t           in_kind,
    input  logic [BYTE_W-1:0]   in_data,
    input  logic                in_last,
    input  logic [QCNT_W-1:0]   q_count,
    output logic                push,
    output kpc_item_t           push_item
);

    logic [LEN_W-1:0]  base_len_reg, base_len_next;
    logic              closed_reg, closed_next;
    logic [LEN_W-1:0]  rp_reg, rp_next;
    logic              s1_valid_reg;
    req_type_t         s1_kind_reg;
    logic [BYTE_W-1:0] s1_data_reg;
    logic              s1_last_reg;
    logic              s1_empty_reg;
    logic              s1_in_range_reg;

    logic              accept;
    logic [LEN_W-1:0]  len_eff;
    logic              wr_en;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_data;
    logic [QCNT_W-1:0] space;

    // Leave a slot for the item that is still waiting for its lookup.
    assign space    = QCNT_W'(QDEPTH) - q_count;
    assign in_ready = s1_valid_reg ? (space >= QCNT_W'(2)) : (space >= QCNT_W'(1));
    assign accept   = in_valid && in_ready;

    assign len_eff = closed_reg ? '0 : base_len_reg;
    assign wr_en   = accept && (in_kind == REQ_BASE) && (len_eff < LEN_W'(KEEP_LEN));
    assign rd_en   = accept && (in_kind == REQ_KEY);

    always_comb begin
        base_len_next = base_len_reg;
        closed_next   = closed_reg;
        rp_next       = rp_reg;
        if (accept) begin
            unique case (in_kind)
                REQ_BASE: begin
                    base_len_next = wr_en ? len_eff + LEN_W'(1) : len_eff;
                    closed_next   = in_last;
                    rp_next       = '0;
                end
                REQ_KEY: begin
                    // The read pointer assumes every key byte matches; once one
                    // does not, the later lookups are not used.
                    rp_next = in_last ? '0 : rp_reg + LEN_W'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_len_reg <= '0;
            closed_reg   <= 1'b1;
            rp_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            base_len_reg <= base_len_next;
            closed_reg   <= closed_next;
            rp_reg       <= rp_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_kind_reg     <= in_kind;
            s1_data_reg     <= in_data;
            s1_last_reg     <= in_last;
            s1_empty_reg    <= (base_len_reg == '0);
            s1_in_range_reg <= (rp_reg < base_len_reg);
        end
    end

    kpc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BASE_DEPTH)
    ) u_base_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (len_eff[ADDR_W-1:0]),
        .wr_data (in_data),
        .rd_en   (rd_en),
        .rd_addr (rp_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign push                 = s1_valid_reg;
    assign push_item.kind       = s1_kind_reg;
    assign push_item.data       = s1_data_reg;
    assign push_item.last       = s1_last_reg;
    assign push_item.base_empty = s1_empty_reg;
    assign push_item.match      = s1_in_range_reg && (rd_data == s1_data_reg);

endmodule

// File: src/kpc_queue.sv
// ----------------------------------------------------------------------------
// kpc_queue: short item queue between front and back end
// A small register FIFO; the front end never pushes into a full queue.
// ----------------------------------------------------------------------------
module kpc_queue
    import kpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  kpc_item_t         push_item,
    input  logic              pop,
    output logic              q_valid,
    output kpc_item_t         q_item,
    output logic [QCNT_W-1:0] q_count
);

    kpc_item_t         slots_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign q_valid = (count_reg != '0);
    assign q_item  = slots_reg[rd_ptr_reg];
    assign q_count = count_reg;

endmodule

// File: src/kpc_back.sv
// ----------------------------------------------------------------------------
// kpc_back: output side of the key prefix compressor
// Keeps the prefix count and match state, and turns classified items into
// result bytes through an output register and a one-entry hold for the
// second result of a mismatching byte.
// ----------------------------------------------------------------------------
module kpc_back
    import kpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  kpc_item_t         q_item,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_last
);

    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [BYTE_W-1:0] pend_data_reg, pend_data_next;
    logic              pend_last_reg, pend_last_next;
    logic [LEN_W-1:0]  prefix_reg, prefix_next;
    logic              matching_reg, matching_next;
    logic              out_free;

    assign out_free = !m_valid_reg || out_ready;
    assign pop      = q_valid && !pend_valid_reg && out_free;

    always_comb begin
        m_valid_next    = m_valid_reg && !out_ready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        pend_last_next  = pend_last_reg;
        prefix_next     = prefix_reg;
        matching_next   = matching_reg;

        if (pend_valid_reg && out_free) begin
            m_valid_next    = 1'b1;
            m_data_next     = pend_data_reg;
            m_last_next     = pend_last_reg;
            pend_valid_next = 1'b0;
        end else if (pop) begin
            priority if (q_item.kind == REQ_BASE) begin
                // A base byte abandons any key in progress.
                prefix_next   = '0;
                matching_next = 1'b1;
            end else if (q_item.base_empty) begin
                if (q_item.last) begin
                    prefix_next   = '0;
                    matching_next = 1'b1;
                end
            end else if (matching_reg && q_item.match) begin
                prefix_next = prefix_reg + LEN_W'(1);
                if (q_item.last) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = prefix_reg + BYTE_W'(1);
                    m_last_next   = 1'b1;
                    prefix_next   = '0;
                    matching_next = 1'b1;
                end
            end else if (matching_reg) begin
                // First mismatch: the count goes out now, the byte right after.
                m_valid_next    = 1'b1;
                m_data_next     = prefix_reg;
                m_last_next     = 1'b0;
                pend_valid_next = 1'b1;
                pend_data_next  = q_item.data;
                pend_last_next  = q_item.last;
                matching_next   = q_item.last;
                if (q_item.last) begin
                    prefix_next = '0;
                end
            end else begin
                m_valid_next = 1'b1;
                m_data_next  = q_item.data;
                m_last_next  = q_item.last;
                if (q_item.last) begin
                    prefix_next   = '0;
                    matching_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            prefix_reg     <= '0;
            matching_reg   <= 1'b1;
        end else begin
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
            prefix_reg     <= prefix_next;
            matching_reg   <= matching_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
        pend_data_reg <= pend_data_next;
        pend_last_reg <= pend_last_next;
    end

    assign out_valid = m_valid_reg;
    assign out_byte  = m_data_reg;
    assign out_last  = m_last_reg;

endmodule

// File: src/key_prefix_compressor.sv
// ----------------------------------------------------------------------------
// key_prefix_compressor: front-coding key compressor
// Stores a base key and emits each following key as a shared-prefix count
// byte and the remaining suffix bytes.
// ----------------------------------------------------------------------------
// Base bytes (tuser = 0) are written into a 256-entry byte RAM, keeping at
// most the first 255; tlast closes the base, and the next base byte starts a
// new one. Key bytes (tuser = 1) are compared against the base at the same
// position: matching bytes give no output, and at the first mismatch, the
// length cap or the key's end the count byte goes out, followed by the
// mismatching byte and all later key bytes, with tlast on the final one. The
// block takes one item per cycle while the queue has room. A key byte that
// breaks the match yields two result bytes and holds the output side while
// the second one waits; a four-entry queue lets input keep flowing meanwhile.
// A key byte's first result passes the base RAM read, which is registered
// together with the byte, then a queue slot and then the output register.
// The base RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module key_prefix_compressor
    import kpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic              s_tuser,   // [0] req_type
    input  logic              s_tlast,   // is_last
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic              m_tlast    // out_last
);

    logic              push;
    kpc_item_t         push_item;
    logic              pop;
    logic              q_valid;
    kpc_item_t         q_item;
    logic [QCNT_W-1:0] q_count;
    req_type_t         in_kind;

    assign in_kind = req_type_t'(s_tuser);

    kpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (in_kind),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .q_count   (q_count),
        .push      (push),
        .push_item (push_item)
    );

    kpc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_count   (q_count)
    );

    kpc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// File: tb/sv/tb_key_prefix_compressor.sv
// ----------------------------------------------------------------------------
// tb_key_prefix_compressor: self-checking testbench of the key compressor
// Streams bases and keys into the block with random gaps on both sides,
// keeps its own front-coding model of the base and the match state, and
// compares every compressed byte and its tlast in order.
// ----------------------------------------------------------------------------
module tb_key_prefix_compressor;
    import kpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int ITEM_TARGET    = 1650;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } compressed_byte_t;

    // Front-coding model: holds the base, the running prefix count and the
    // compressed bytes still to come out of the block.
    class front_code_tracker;
        logic [BYTE_W-1:0] base_mem [BASE_DEPTH];
        int unsigned       base_len;
        bit                base_closed;
        int unsigned       prefix_cnt;
        bit                matching;
        compressed_byte_t  pending_bytes [$];
        int unsigned       errors;

        function new();
            base_len    = 0;
            base_closed = 1'b1;
            prefix_cnt  = 0;
            matching    = 1'b1;
            errors      = 0;
        endfunction

        function void queue_byte(logic [BYTE_W-1:0] value, logic last);
            compressed_byte_t entry;
            entry.value = value;
            entry.last  = last;
            pending_bytes.push_back(entry);
        endfunction

        function void accept_input(req_type_t kind, logic [BYTE_W-1:0] data, logic last);
            if (kind == REQ_BASE) begin
                if (base_closed) begin
                    base_len    = 0;
                    base_closed = 1'b0;
                end
                if (base_len < KEEP_LEN) begin
                    base_mem[base_len] = data;
                    base_len++;
                end
                if (last) begin
                    base_closed = 1'b1;
                end
                // A base byte abandons any key in progress.
                prefix_cnt = 0;
                matching   = 1'b1;
            end else if (base_len == 0) begin
                if (last) begin
                    prefix_cnt = 0;
                    matching   = 1'b1;
                end
            end else begin
                if (matching) begin
                    if (prefix_cnt < base_len && prefix_cnt < BASE_DEPTH &&
                        base_mem[prefix_cnt] == data) begin
                        prefix_cnt++;
                        if (last) begin
                            queue_byte(8'(prefix_cnt), 1'b1);
                        end
                    end else begin
                        queue_byte(8'(prefix_cnt), 1'b0);
                        queue_byte(data, last);
                        matching = 1'b0;
                    end
                end else begin
                    queue_byte(data, last);
                end
                if (last) begin
                    prefix_cnt = 0;
                    matching   = 1'b1;
                end
            end
        endfunction

        task report(string msg);
            if (errors < 50) begin
                $display("ERROR at %0t: %s", $time, msg);
            end
            errors++;
        endtask

        task check_output(logic [BYTE_W-1:0] value, logic last);
            compressed_byte_t want;
            if (pending_bytes.size() == 0) begin
                report($sformatf("unexpected result byte %02h last %0b", value, last));
            end else begin
                want = pending_bytes.pop_front();
                if (value !== want.value) begin
                    report($sformatf("result byte %02h, expected %02h", value, want.value));
                end
                if (last !== want.last) begin
                    report($sformatf("tlast %0b on byte %02h, expected %0b",
                                     last, value, want.last));
                end
            end
        endtask
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata;    // [7:0] data_byte
    logic              s_tuser;    // [0] req_type
    logic              s_tlast;    // is_last
    logic              m_tvalid;
    logic              m_tready;
    logic [BYTE_W-1:0] m_tdata;    // [7:0] out_byte
    logic              m_tlast;    // out_last

    front_code_tracker tracker;
    int unsigned       items_sent;
    int unsigned       idle_cycles;
    bit                steady;
    // Copy of the base as sent, used to build keys that share a prefix.
    logic [BYTE_W-1:0] base_copy [$];
    bit                base_done = 1'b1;

    key_prefix_compressor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(req_type_t kind, logic [BYTE_W-1:0] data, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (kind == REQ_BASE) begin
            if (base_done) begin
                base_copy.delete();
            end
            base_copy.push_back(data);
            base_done = last;
        end
    endtask

    task automatic send_base(int n, bit close);
        for (int i = 0; i < n; i++) begin
            send_item(REQ_BASE, 8'($urandom), close && (i == n - 1));
        end
    endtask

    // Sends a key whose first match_len bytes copy the base where it has them;
    // the byte right after that prefix is forced to differ where the base has one.
    task automatic send_key(int len, int match_len);
        logic [BYTE_W-1:0] data;
        for (int i = 0; i < len; i++) begin
            if (i < match_len && i < base_copy.size()) begin
                data = base_copy[i];
            end else if (i == match_len && i < base_copy.size()) begin
                data = base_copy[i] ^ 8'($urandom_range(1, 255));
            end else begin
                data = 8'($urandom);
            end
            send_item(REQ_KEY, data, i == len - 1);
        end
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.pending_bytes.size() != 0);
    endtask

    task automatic send_random_key();
        int kept;
        int len;
        kept = (base_copy.size() < KEEP_LEN) ? base_copy.size() : KEEP_LEN;
        case ($urandom_range(0, 3))
            0: begin
                len = $urandom_range(1, (kept < 40) ? kept : 40);
                send_key(len, len);
            end
            1: begin
                if (kept <= 40 || $urandom_range(0, 2) == 0) begin
                    len = kept + $urandom_range(0, 3);
                    send_key(len, len);
                end else begin
                    len = $urandom_range(1, 40);
                    send_key(len, $urandom_range(0, len));
                end
            end
            default: begin
                len = $urandom_range(1, ((kept < 30) ? kept : 30) + 3);
                send_key(len, $urandom_range(0, len));
            end
        endcase
    endtask

    // Checks both channels at each edge; inputs are noted before outputs.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tracker.accept_input(req_type_t'(s_tuser), s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                tracker.check_output(m_tdata, m_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int run_len;
        int stall;
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            run_len = $urandom_range(1, 24);
            m_tready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    initial begin
        int bases_made;
        int pick;
        tracker     = new();
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = REQ_BASE;
        s_tlast     = 1'b0;
        items_sent  = 0;
        steady      = 1'b0;
        bases_made  = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Keys before any base give nothing.
        send_item(REQ_KEY, 8'h5A, 1'b1);
        send_item(REQ_KEY, 8'h00, 1'b0);
        send_item(REQ_KEY, 8'hFF, 1'b1);
        send_item(REQ_BASE, 8'h00, 1'b0);
        send_item(REQ_BASE, 8'hFF, 1'b0);
        send_item(REQ_BASE, 8'h80, 1'b1);
        // Key that ends while still matching: only the count goes out.
        send_item(REQ_KEY, 8'h00, 1'b0);
        send_item(REQ_KEY, 8'hFF, 1'b0);
        send_item(REQ_KEY, 8'h80, 1'b1);
        // Mismatch at the first byte.
        send_item(REQ_KEY, 8'h01, 1'b1);
        // Mismatch in the middle, then a suffix byte.
        send_item(REQ_KEY, 8'h00, 1'b0);
        send_item(REQ_KEY, 8'h7F, 1'b0);
        send_item(REQ_KEY, 8'h55, 1'b1);
        // Key longer than the base runs past the base's end.
        send_item(REQ_KEY, 8'h00, 1'b0);
        send_item(REQ_KEY, 8'hFF, 1'b0);
        send_item(REQ_KEY, 8'h80, 1'b0);
        send_item(REQ_KEY, 8'hAA, 1'b1);
        // A base byte cuts the key short, and a key then runs on the open base.
        send_item(REQ_KEY, 8'h00, 1'b0);
        send_item(REQ_KEY, 8'h11, 1'b0);
        send_item(REQ_BASE, 8'h42, 1'b0);
        send_item(REQ_KEY, 8'h42, 1'b1);
        send_item(REQ_BASE, 8'h43, 1'b1);
        wait_for_drain();

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 19) == 0) begin
                steady = ~steady;
            end
            if (items_sent > ITEM_TARGET / 2 && items_sent < ITEM_TARGET / 2 + 40) begin
                wait_for_drain();
            end
            pick = $urandom_range(0, 99);
            if (pick < 12 || base_copy.size() == 0) begin
                // Base three and rare others are long; the rest stay short.
                if (bases_made == 2 || $urandom_range(0, 79) == 0) begin
                    send_base($urandom_range(250, 300), 1'b1);
                end else begin
                    send_base($urandom_range(1, 24), 1'b1);
                end
                bases_made++;
            end else if (pick < 80) begin
                send_random_key();
            end else if (pick < 90) begin
                send_base($urandom_range(1, 5), 1'b0);
                send_random_key();
                send_base($urandom_range(1, 4), 1'b1);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(req_type_t'($urandom_range(0, 1)), 8'($urandom),
                              1'($urandom_range(0, 1)));
                end
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.pending_bytes.size() != 0) begin
            tracker.report($sformatf("%0d result bytes never arrived",
                                     tracker.pending_bytes.size()));
        end
        if (tracker.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/kpc_pkg.sv
src/kpc_ram.sv
src/kpc_front.sv
src/kpc_queue.sv
src/kpc_back.sv
src/key_prefix_compressor.sv
tb/sv/tb_key_prefix_compressor.sv
